// ===== rtl/slab_pkg.sv =====
`default_nettype none

package slab_pkg;

  localparam int RGB_W  = 8;
  localparam int Q      = 24;
  localparam int LIN_W  = 25;
  localparam int PROD_W = 49;
  localparam int SUM_W  = 49;
  localparam int WN_W   = 45;
  localparam int W_W    = 25;
  localparam int F_W    = 25;
  localparam int LF_W   = 40;
  localparam int L_W    = 15;
  localparam int AB_W   = 16;

  localparam int OUT_FRAC_BITS_DEF = 8;

  // D65 sRGB to XYZ matrix, coefficients scaled by 10^7
  localparam logic [23:0] M_XR = 24'd4124564;
  localparam logic [23:0] M_XG = 24'd3575761;
  localparam logic [23:0] M_XB = 24'd1804375;
  localparam logic [23:0] M_YR = 24'd2126729;
  localparam logic [23:0] M_YG = 24'd7151522;
  localparam logic [23:0] M_YB = 24'd721750;
  localparam logic [23:0] M_ZR = 24'd193339;
  localparam logic [23:0] M_ZG = 24'd1191920;
  localparam logic [23:0] M_ZB = 24'd9503041;

  localparam logic [63:0] MAT_DIV  = 64'd10000000;
  localparam logic [63:0] MAT_HALF = 64'd5000000;

  // Reference white
  localparam logic [63:0] WHT_MUL  = 64'd1000000;
  localparam logic [63:0] WX_DIV   = 64'd950456;
  localparam logic [63:0] WX_HALF  = 64'd475228;
  localparam logic [63:0] WZ_DIV   = 64'd1088754;
  localparam logic [63:0] WZ_HALF  = 64'd544377;

  // Lab f(): cube root above epsilon, kappa line below
  localparam logic [W_W-1:0] W_THR  = W_W'(((64'd8856 << Q) / 64'd1000000) + 64'd1);
  localparam logic [63:0]    LF_MUL = 64'd9033;
  localparam logic [63:0]    LF_OFS = (64'd160 << Q) + 64'd580;
  localparam logic [63:0]    LF_DIV = 64'd1160;

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  typedef struct packed {
    logic        [L_W-1:0]  lightness;
    logic signed [AB_W-1:0] green_red;
    logic signed [AB_W-1:0] blue_yellow;
  } lab_pix_t;

  function automatic logic [63:0] p5(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] u4;
    u2 = (u * u) >> Q;
    u4 = (u2 * u2) >> Q;
    return (u4 * u) >> Q;
  endfunction

  // Gamma expansion of one code, evaluated at elaboration only
  function automatic logic [LIN_W-1:0] lin_of(input int unsigned v);
    logic [63:0] vv;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    vv = 64'(v);
    if (vv * 64'd100000 <= 64'd1031475) begin
      return LIN_W'((vv * 64'd100 * (64'd1 << Q) + 64'd164730) / 64'd329460);
    end
    t  = (((64'd1000 * vv + 64'd14025) << Q) + 64'd134512) / 64'd269025;
    t2 = (t * t) >> Q;
    lo = 64'd0;
    hi = 64'd1 << Q;
    for (int i = 0; i < 30; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (p5(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return LIN_W'((t2 * lo) >> Q);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = lin_of(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

`default_nettype wire

// ===== rtl/slab_if.sv =====
`default_nettype none

interface slab_pix_if;
  import slab_pkg::*;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] red;
  logic [RGB_W-1:0] green;
  logic [RGB_W-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface slab_lab_if;
  import slab_pkg::*;
  logic                   valid;
  logic                   ready;
  logic        [L_W-1:0]  lightness;
  logic signed [AB_W-1:0] green_red;
  logic signed [AB_W-1:0] blue_yellow;
  modport source (output valid, output lightness, output green_red, output blue_yellow,
                  input ready);
  modport sink   (input valid, input lightness, input green_red, input blue_yellow,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/slab_cdiv.sv =====
`default_nettype none

// Floor division by a constant: reciprocal estimate, then remainder fix-up.
module slab_cdiv #(
  parameter  int          NW = 48,
  parameter  logic [63:0] D  = 64'd10,
  localparam int          SH = $clog2(D) - 1,
  localparam int          QW = NW - SH
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  output logic [QW-1:0] q
);

  localparam int          DW = $clog2(D + 64'd1);
  localparam logic [63:0] M  = (64'd1 << NW) / D;
  localparam logic [NW+1:0] D1 = (NW+2)'(D);
  localparam logic [NW+1:0] D2 = (NW+2)'(D * 64'd2);

  logic [2*QW-1:0]  prod_r;
  logic [NW-1:0]    n1_r;
  logic [NW-1:0]    n2_r;
  logic [NW-1:0]    qd_r;
  logic [QW-1:0]    q0_r;
  logic [QW-1:0]    q_r;
  logic [QW-1:0]    q0;
  logic [QW+DW-1:0] qd;
  logic [NW+1:0]    rem;

  // estimate undershoots by at most two
  assign q0  = prod_r[2*QW-1:QW];
  assign qd  = (QW+DW)'(q0) * (QW+DW)'(D);
  assign rem = (NW+2)'(n2_r) - (NW+2)'(qd_r);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (2*QW)'(n[NW-1:SH]) * (2*QW)'(M);
      n1_r   <= n;
      q0_r   <= q0;
      qd_r   <= qd[NW-1:0];
      n2_r   <= n1_r;
      if (rem >= D2) begin
        q_r <= q0_r + QW'(2);
      end else if (rem >= D1) begin
        q_r <= q0_r + QW'(1);
      end else begin
        q_r <= q0_r;
      end
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/slab_cbrt.sv =====
`default_nettype none

// Largest c with floor(floor(c*c/2^24)*c/2^24) <= w, one result bit per stage.
module slab_cbrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [slab_pkg::W_W-1:0] w,
  output logic [slab_pkg::F_W-1:0] c
);
  import slab_pkg::*;

  localparam int NB = F_W;

  logic [F_W-1:0]   c_r  [NB];
  logic [2*F_W-1:0] sq_r [NB];
  logic [W_W-1:0]   w_r  [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stg
    localparam int BIT = NB - 1 - i;
    logic [F_W-1:0]   pc;
    logic [2*F_W-1:0] psq;
    logic [W_W-1:0]   pw;
    logic [F_W-1:0]   cand;
    logic [2*F_W-1:0] cand_sq;
    logic [F_W:0]     c2;
    logic [2*F_W+1:0] cube_full;
    logic             fits;

    if (i == 0) begin : g_first
      assign pc  = '0;
      assign psq = '0;
      assign pw  = w;
    end else begin : g_next
      assign pc  = c_r[i-1];
      assign psq = sq_r[i-1];
      assign pw  = w_r[i-1];
    end

    // exact square of the trial value, built from the last square
    assign cand      = pc | (F_W'(1) << BIT);
    assign cand_sq   = psq + ((2*F_W)'(pc) << (BIT + 1)) + ((2*F_W)'(1) << (2 * BIT));
    assign c2        = cand_sq[2*F_W-1:Q];
    assign cube_full = (2*F_W+2)'(c2) * (2*F_W+2)'(cand);
    assign fits      = cube_full[2*F_W+1:Q] <= (2*F_W+2-Q)'(pw);

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[i]  <= fits ? cand : pc;
        sq_r[i] <= fits ? cand_sq : psq;
        w_r[i]  <= pw;
      end
    end
  end

  assign c = c_r[NB-1];

endmodule

`default_nettype wire

// ===== rtl/slab_labf.sv =====
`default_nettype none

// CIE f(): cube root path and kappa line run side by side, picked at the end.
module slab_labf (
  input  logic                     clk,
  input  logic                     en,
  input  logic [slab_pkg::W_W-1:0] w,
  output logic [slab_pkg::F_W-1:0] f
);
  import slab_pkg::*;

  localparam int LAT    = F_W;
  localparam int LF_QW  = LF_W - ($clog2(LF_DIV) - 1);
  localparam int LF_DLY = LAT - 3;

  logic [F_W-1:0]   root;
  logic [LF_W-1:0]  lf_num;
  logic [LF_QW-1:0] lf_q;
  logic [F_W-1:0]   lin_d_r [LF_DLY];
  logic [LAT-1:0]   sel_r;

  slab_cbrt u_cbrt (
    .clk (clk),
    .en  (en),
    .w   (w),
    .c   (root)
  );

  assign lf_num = LF_W'(w) * LF_W'(LF_MUL) + LF_W'(LF_OFS);

  slab_cdiv #(.NW(LF_W), .D(LF_DIV)) u_lfdiv (
    .clk (clk),
    .en  (en),
    .n   (lf_num),
    .q   (lf_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= {sel_r[LAT-2:0], (w >= W_THR)};
      lin_d_r[0] <= lf_q[F_W-1:0];
      for (int i = 1; i < LF_DLY; i++) begin
        lin_d_r[i] <= lin_d_r[i-1];
      end
    end
  end

  assign f = sel_r[LAT-1] ? root : lin_d_r[LF_DLY-1];

endmodule

`default_nettype wire

// ===== rtl/srgb_to_lab_pixel.sv =====
// sRGB (D65) to CIE L*a*b* converter, one pixel per beat.
// 36 pipeline stages plus the output buffer; depth set by the bit-per-stage cube-root units.
// Throughput: one pixel per cycle unless the output buffer is full.
// A two-entry output buffer keeps the input side open while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline valid bits and the output buffer.
`default_nettype none

module srgb_to_lab_pixel #(
  parameter int OUT_FRAC_BITS = slab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slab_pix_if.sink    in_pix,
  slab_lab_if.source  out_lab
);
  import slab_pkg::*;

  // Stage map: lookup, products, sums, /1e7 (3), white scale, white divide (3),
  // f() (25), Lab combine
  localparam int NSTG  = 36;
  localparam int LAST  = NSTG - 1;
  localparam int MQW   = SUM_W - ($clog2(MAT_DIV) - 1);
  localparam int XQW   = WN_W - ($clog2(WX_DIV) - 1);
  localparam int ZQW   = WN_W - ($clog2(WZ_DIV) - 1);
  localparam int SHIFT = Q - OUT_FRAC_BITS;
  localparam int LW_MAX_I = ((100 << OUT_FRAC_BITS) < 32767) ? (100 << OUT_FRAC_BITS) : 32767;
  localparam logic [L_W-1:0] L_MAX = L_W'(LW_MAX_I);
  localparam logic [35:0] HALF  = 36'd1 << (SHIFT - 1);
  localparam logic signed [35:0] L_OFS = 36'sd268435456;

  logic             adv;
  logic [NSTG-1:0]  v_r;

  logic [LIN_W-1:0]  lr_r, lg_r, lb_r;
  logic [PROD_W-1:0] prod_r [9];
  logic [SUM_W-1:0]  sx_r, sy_r, sz_r;
  logic [MQW-1:0]    xq, yq, zq;
  logic [WN_W-1:0]   xn_r, zn_r;
  logic [W_W-1:0]    yd_r [4];
  logic [XQW-1:0]    xw;
  logic [ZQW-1:0]    zw;
  logic [F_W-1:0]    fx, fy, fz;
  logic signed [35:0] l_r, a_r, b_r;

  lab_pix_t          res;
  lab_pix_t          ent_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  // Stall the whole pipeline only when the output buffer is full
  assign adv          = (cnt_r != 2'd2);
  assign in_pix.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_pix.valid};
    end
  end

  // Gamma expansion by table, then the matrix products and sums
  always_ff @(posedge clk) begin
    if (adv) begin
      lr_r <= LIN_TAB[in_pix.red];
      lg_r <= LIN_TAB[in_pix.green];
      lb_r <= LIN_TAB[in_pix.blue];
      prod_r[0] <= PROD_W'(lr_r) * PROD_W'(M_XR);
      prod_r[1] <= PROD_W'(lg_r) * PROD_W'(M_XG);
      prod_r[2] <= PROD_W'(lb_r) * PROD_W'(M_XB);
      prod_r[3] <= PROD_W'(lr_r) * PROD_W'(M_YR);
      prod_r[4] <= PROD_W'(lg_r) * PROD_W'(M_YG);
      prod_r[5] <= PROD_W'(lb_r) * PROD_W'(M_YB);
      prod_r[6] <= PROD_W'(lr_r) * PROD_W'(M_ZR);
      prod_r[7] <= PROD_W'(lg_r) * PROD_W'(M_ZG);
      prod_r[8] <= PROD_W'(lb_r) * PROD_W'(M_ZB);
      sx_r <= prod_r[0] + prod_r[1] + prod_r[2] + SUM_W'(MAT_HALF);
      sy_r <= prod_r[3] + prod_r[4] + prod_r[5] + SUM_W'(MAT_HALF);
      sz_r <= prod_r[6] + prod_r[7] + prod_r[8] + SUM_W'(MAT_HALF);
    end
  end

  slab_cdiv #(.NW(SUM_W), .D(MAT_DIV)) u_xdiv (.clk(clk), .en(adv), .n(sx_r), .q(xq));
  slab_cdiv #(.NW(SUM_W), .D(MAT_DIV)) u_ydiv (.clk(clk), .en(adv), .n(sy_r), .q(yq));
  slab_cdiv #(.NW(SUM_W), .D(MAT_DIV)) u_zdiv (.clk(clk), .en(adv), .n(sz_r), .q(zq));

  // Scale X and Z for the white divide; hold Y alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      xn_r <= WN_W'(xq[W_W-1:0]) * WN_W'(WHT_MUL) + WN_W'(WX_HALF);
      zn_r <= WN_W'(zq[W_W-1:0]) * WN_W'(WHT_MUL) + WN_W'(WZ_HALF);
      yd_r[0] <= yq[W_W-1:0];
      for (int i = 1; i < 4; i++) begin
        yd_r[i] <= yd_r[i-1];
      end
    end
  end

  slab_cdiv #(.NW(WN_W), .D(WX_DIV)) u_wxdiv (.clk(clk), .en(adv), .n(xn_r), .q(xw));
  slab_cdiv #(.NW(WN_W), .D(WZ_DIV)) u_wzdiv (.clk(clk), .en(adv), .n(zn_r), .q(zw));

  slab_labf u_fx (.clk(clk), .en(adv), .w(xw[W_W-1:0]), .f(fx));
  slab_labf u_fy (.clk(clk), .en(adv), .w(yd_r[3]),     .f(fy));
  slab_labf u_fz (.clk(clk), .en(adv), .w(zw[W_W-1:0]), .f(fz));

  always_ff @(posedge clk) begin
    if (adv) begin
      l_r <= signed'(36'(fy) * 36'd116) - L_OFS;
      a_r <= 36'sd500 * (signed'(36'(fx)) - signed'(36'(fy)));
      b_r <= 36'sd200 * (signed'(36'(fy)) - signed'(36'(fz)));
    end
  end

  // Round half away from zero to the output fraction width
  function automatic logic signed [35:0] scale_out(input logic signed [35:0] v);
    logic [35:0] mag;
    mag = v[35] ? 36'(-v) : 36'(v);
    mag = (mag + HALF) >> SHIFT;
    return v[35] ? -signed'(mag) : signed'(mag);
  endfunction

  always_comb begin
    logic signed [35:0] ls, as, bs;
    ls = scale_out(l_r);
    as = scale_out(a_r);
    bs = scale_out(b_r);
    if (ls < 0) begin
      res.lightness = '0;
    end else if (ls > 36'sd32767) begin
      res.lightness = L_W'(32767);
    end else begin
      res.lightness = ls[L_W-1:0];
    end
    if (as < -36'sd32768) begin
      res.green_red = -16'sd32768;
    end else if (as > 36'sd32767) begin
      res.green_red = 16'sd32767;
    end else begin
      res.green_red = as[AB_W-1:0];
    end
    if (bs < -36'sd32768) begin
      res.blue_yellow = -16'sd32768;
    end else if (bs > 36'sd32767) begin
      res.blue_yellow = 16'sd32767;
    end else begin
      res.blue_yellow = bs[AB_W-1:0];
    end
  end

  // Output buffer: two entries, so the pipeline never drops a beat
  assign push = adv && v_r[LAST];
  assign pop  = out_lab.valid && out_lab.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= res;
    end
  end

  assign out_lab.valid       = (cnt_r != 2'd0);
  assign out_lab.lightness   = ent_r[rp_r].lightness;
  assign out_lab.green_red   = ent_r[rp_r].green_red;
  assign out_lab.blue_yellow = ent_r[rp_r].blue_yellow;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("output buffer count out of range");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("pushed beat not held in output buffer");

  a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_lab.valid |-> (out_lab.lightness <= L_MAX))
    else $error("lightness beyond full scale");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> !out_lab.valid)
    else $error("output valid without a buffered beat");

endmodule

`default_nettype wire
